// File: design/jacobi_heat_stencil_core_defines.svh
// assertion macros for the jacobi heat stencil core checker
// depends on nothing; included by the checker file only
`ifndef JACOBI_HEAT_STENCIL_CORE_DEFINES_SVH
`define JACOBI_HEAT_STENCIL_CORE_DEFINES_SVH

// same-cycle implication
`define JHS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define JHS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/jhs_pkg.sv
// shared types and constants of the jacobi heat stencil core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jhs_pkg;

   localparam int MAX_SIDE_DEF = 128;

   localparam int CMD_W   = 2;
   localparam int COORD_W = 7;
   localparam int TEMP_W  = 16;
   localparam int SWEEP_W = 16;
   localparam int GRID_W  = 8;
   localparam int SUM_W   = TEMP_W + 2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE   = 1'b1;

   localparam logic [SWEEP_W-1:0] SWEEP_COUNT_RST = 16'd1;
   localparam logic [GRID_W-1:0]  GRID_SIZE_RST   = 8'd100;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_NEXT  = 4'b0010,
      ST_SWEEP = 4'b0100,
      ST_DRAIN = 4'b1000
   } seq_state_type;

   // sequencer status toward the top level
   typedef struct packed {
      logic busy;
      logic done;
      logic half;
      logic rd_en;
      logic wr_en;
   } seq_status_type;

endpackage

`default_nettype wire

// File: design/jhs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module jhs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/jhs_sweep_seq.sv
// sweep sequencer: walks interior cells, reads four neighbors, writes the average
// depends on jhs_pkg
`timescale 1ns / 1ps
`default_nettype none

module jhs_sweep_seq #(
   parameter int MAX_SIDE = jhs_pkg::MAX_SIDE_DEF
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        run_start,
   input  wire logic [jhs_pkg::SWEEP_W-1:0]                 sweep_count,
   input  wire logic [((($clog2(MAX_SIDE)+1) > jhs_pkg::GRID_W) ?
                       ($clog2(MAX_SIDE)+1) : jhs_pkg::GRID_W)-1:0] side,
   input  wire logic [jhs_pkg::TEMP_W-1:0]                  src_data,
   output jhs_pkg::seq_status_type                          status,
   output logic      [2*$clog2(MAX_SIDE)-1:0]               rd_addr,
   output logic      [2*$clog2(MAX_SIDE)-1:0]               wr_addr,
   output logic      [jhs_pkg::TEMP_W-1:0]                  wr_data
);

   import jhs_pkg::*;

   localparam int CW = $clog2(MAX_SIDE);
   localparam int AW = 2 * CW;
   localparam int SW = ((CW + 1) > GRID_W) ? (CW + 1) : GRID_W;

   localparam logic [1:0] PH_NORTH = 2'd0;
   localparam logic [1:0] PH_SOUTH = 2'd1;
   localparam logic [1:0] PH_WEST  = 2'd2;
   localparam logic [1:0] PH_EAST  = 2'd3;

   seq_state_type      state_ff, state_in;
   logic [SWEEP_W-1:0] left_ff, left_in;
   logic [CW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [1:0]         phase_ff, phase_in;
   logic               half_ff, half_in;
   logic               done_ff, done_in;

   // read data pipeline
   logic               rv_ff, rfirst_ff, rlast_ff;
   logic [AW-1:0]      wb_addr_ff;
   logic [SUM_W-1:0]   acc_ff, acc_in, sum;

   logic [SW-1:0]      side_m2;
   logic               col_end, row_end;
   logic [CW-1:0]      ar, ac;

   assign side_m2 = side - SW'(2);
   assign col_end = (SW'(col_ff) == side_m2);
   assign row_end = (SW'(row_ff) == side_m2);

   always_comb begin
      ar = row_ff;
      ac = col_ff;
      case (phase_ff)
         PH_NORTH: ar = row_ff - CW'(1);
         PH_SOUTH: ar = row_ff + CW'(1);
         PH_WEST:  ac = col_ff - CW'(1);
         PH_EAST:  ac = col_ff + CW'(1);
         default:  ar = row_ff;
      endcase
   end

   assign rd_addr = {ar, ac};

   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      phase_in = phase_ff;
      half_in  = half_ff;
      done_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (run_start) begin
               left_in  = sweep_count;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (left_ff == '0) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               left_in = left_ff - SWEEP_W'(1);
               if (side >= SW'(3)) begin
                  row_in   = CW'(1);
                  col_in   = CW'(1);
                  phase_in = PH_NORTH;
                  state_in = ST_SWEEP;
               end else begin
                  // no interior cells, the grid still changes halves
                  half_in = ~half_ff;
               end
            end
         end
         ST_SWEEP: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == PH_EAST) begin
               if (col_end) begin
                  col_in = CW'(1);
                  row_in = row_ff + CW'(1);
                  if (row_end) begin
                     state_in = ST_DRAIN;
                  end
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
         end
         ST_DRAIN: begin
            // last write-back lands this cycle
            half_in  = ~half_ff;
            state_in = ST_NEXT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign sum     = acc_ff + SUM_W'(src_data);
   assign acc_in  = rfirst_ff ? SUM_W'(src_data) : sum;
   assign wr_data = sum[SUM_W-1:2];
   assign wr_addr = wb_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         left_ff   <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         phase_ff  <= PH_NORTH;
         half_ff   <= 1'b0;
         done_ff   <= 1'b0;
         rv_ff     <= 1'b0;
         rfirst_ff <= 1'b0;
         rlast_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         left_ff   <= left_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         phase_ff  <= phase_in;
         half_ff   <= half_in;
         done_ff   <= done_in;
         rv_ff     <= (state_ff == ST_SWEEP);
         rfirst_ff <= (phase_ff == PH_NORTH);
         rlast_ff  <= (phase_ff == PH_EAST);
      end
   end

   always_ff @(posedge clock) begin
      if (rv_ff) begin
         acc_ff <= acc_in;
      end
      if (state_ff == ST_SWEEP && phase_ff == PH_EAST) begin
         wb_addr_ff <= {row_ff, col_ff};
      end
   end

   assign status.busy  = (state_ff != ST_IDLE);
   assign status.done  = done_ff;
   assign status.half  = half_ff;
   assign status.rd_en = (state_ff == ST_SWEEP);
   assign status.wr_en = rv_ff & rlast_ff;

endmodule

`default_nettype wire

// File: design/jacobi_heat_stencil_core.sv
// jacobi heat stencil core: write, read and run commands over a ping-pong grid store
// throughput: one write or read transfer per cycle while busy is low; a write gives no
// result, a read result shows in the cycle after the transfer. a run keeps busy high
// until all its sweeps are done, their length set by the single read port of the
// source half: four neighbor reads per interior cell; the run's done strobe shows in the
// first cycle with busy low. the receiver cannot stall results.
// reset: registers go to their defaults, grid contents are undefined until written.
// depends on jhs_pkg, jhs_ram, jhs_sweep_seq
`timescale 1ns / 1ps
`default_nettype none

module jacobi_heat_stencil_core #(
   parameter int MAX_SIDE = jhs_pkg::MAX_SIDE_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // command channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [jhs_pkg::CMD_W-1:0]         req_command,
   input  wire logic [jhs_pkg::COORD_W-1:0]       req_row,
   input  wire logic [jhs_pkg::COORD_W-1:0]       req_column,
   input  wire logic [jhs_pkg::TEMP_W-1:0]        req_temperature,
   // result channel, one-cycle strobe
   output logic                                   rsp_valid,
   output logic      [jhs_pkg::TEMP_W-1:0]        rsp_cell_value,
   output logic                                   rsp_run_done,
   // register writes
   input  wire logic                              csr_we,
   input  wire logic [jhs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [jhs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import jhs_pkg::*;

   localparam int CW    = $clog2(MAX_SIDE);
   localparam int AW    = 2 * CW;
   localparam int DEPTH = 1 << AW;
   localparam int SW    = ((CW + 1) > GRID_W) ? (CW + 1) : GRID_W;

   // configuration registers
   logic [SWEEP_W-1:0] sweep_count_ff;
   logic [GRID_W-1:0]  grid_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_count_ff <= SWEEP_COUNT_RST;
         grid_size_ff   <= GRID_SIZE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SWEEP_COUNT: sweep_count_ff <= csr_wdata[SWEEP_W-1:0];
            CSR_GRID_SIZE:   grid_size_ff   <= csr_wdata[GRID_W-1:0];
            default:         sweep_count_ff <= sweep_count_ff;
         endcase
      end
   end

   // side in use is clipped to the store's stride
   logic [SW-1:0] side;
   assign side = (32'(grid_size_ff) < MAX_SIDE) ? SW'(grid_size_ff) : SW'(MAX_SIDE);

   // command decode
   seq_status_type seq_st;
   logic           accept;
   logic           cmd_wr, cmd_rd, cmd_run;
   logic           in_range;
   logic [AW-1:0]  cmd_addr;
   cmd_type        cmd;

   assign busy    = seq_st.busy;
   assign accept  = start & ~seq_st.busy;
   assign cmd     = cmd_type'(req_command);
   assign in_range = (32'(req_row) < MAX_SIDE) && (32'(req_column) < MAX_SIDE);
   assign cmd_addr = {CW'(req_row), CW'(req_column)};

   always_comb begin
      cmd_wr  = 1'b0;
      cmd_rd  = 1'b0;
      cmd_run = 1'b0;
      case (cmd)
         CMD_WRITE: cmd_wr  = accept;
         CMD_RUN:   cmd_run = accept;
         CMD_READ:  cmd_rd  = accept;
         default:   cmd_wr  = 1'b0;   // unused code is dropped
      endcase
   end

   // memory access muxing; commands and sweeps never overlap
   logic [AW-1:0]     seq_rd_addr, seq_wr_addr;
   logic [TEMP_W-1:0] seq_wr_data;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [TEMP_W-1:0] wr_data;
   logic              rd_en;
   logic              we0, we1;
   logic [TEMP_W-1:0] rdata0, rdata1, src_data;

   assign rd_en   = seq_st.rd_en | cmd_rd;
   assign rd_addr = seq_st.busy ? seq_rd_addr : cmd_addr;
   assign wr_addr = seq_st.wr_en ? seq_wr_addr : cmd_addr;
   assign wr_data = seq_st.wr_en ? seq_wr_data : req_temperature;

   // a cell write lands in both halves so borders agree; sweeps write the other half
   assign we0 = (cmd_wr & in_range) | (seq_st.wr_en &  seq_st.half);
   assign we1 = (cmd_wr & in_range) | (seq_st.wr_en & ~seq_st.half);

   // half only flips when no read data is in flight
   assign src_data = seq_st.half ? rdata1 : rdata0;

   jhs_ram #(
      .WIDTH (TEMP_W),
      .DEPTH (DEPTH)
   ) u_half0 (
      .clock (clock),
      .we    (we0),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rdata0)
   );

   jhs_ram #(
      .WIDTH (TEMP_W),
      .DEPTH (DEPTH)
   ) u_half1 (
      .clock (clock),
      .we    (we1),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rdata1)
   );

   jhs_sweep_seq #(
      .MAX_SIDE (MAX_SIDE)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .run_start   (cmd_run),
      .sweep_count (sweep_count_ff),
      .side        (side),
      .src_data    (src_data),
      .status      (seq_st),
      .rd_addr     (seq_rd_addr),
      .wr_addr     (seq_wr_addr),
      .wr_data     (seq_wr_data)
   );

   // read result follows the ram's registered read data
   logic rd_pend_ff;
   logic rd_inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_rd) begin
         rd_inside_ff <= in_range;
      end
   end

   // a read result and a run done can never share a cycle
   assign rsp_valid      = rd_pend_ff | seq_st.done;
   assign rsp_cell_value = (rd_pend_ff & rd_inside_ff) ? src_data : '0;
   assign rsp_run_done   = seq_st.done;

endmodule

`default_nettype wire

// File: design/jhs_checker.sv
// port-level checks on the jacobi heat stencil core, bound to the top level
// depends on jhs_pkg and jacobi_heat_stencil_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "jacobi_heat_stencil_core_defines.svh"

module jhs_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic [jhs_pkg::CMD_W-1:0]      req_command,
   input wire logic                           rsp_valid,
   input wire logic [jhs_pkg::TEMP_W-1:0]     rsp_cell_value,
   input wire logic                           rsp_run_done
);

   import jhs_pkg::*;

   logic rd_xfer, run_xfer;

   assign rd_xfer  = start && !busy && (req_command == CMD_READ);
   assign run_xfer = start && !busy && (req_command == CMD_RUN);

   `JHS_ASSERT_NXT(a_read_answers, clock, reset, rd_xfer, rsp_valid && !rsp_run_done, "read transfer without read result")

   `JHS_ASSERT_NXT(a_run_busy, clock, reset, run_xfer, busy && !rsp_valid, "run transfer did not raise busy")

   `JHS_ASSERT_IMP(a_done_strobed, clock, reset, rsp_run_done, rsp_valid && rsp_cell_value == '0, "run done without strobe or with data")

   `JHS_ASSERT_IMP(a_done_ends_busy, clock, reset, rsp_run_done, !busy && $past(busy), "run done not at end of busy")

   `JHS_ASSERT_IMP(a_no_result_in_run, clock, reset, busy, !rsp_valid, "result while run in progress")

endmodule

bind jacobi_heat_stencil_core jhs_checker u_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for jacobi_heat_stencil_core: write, read and run commands
// checked against a built-in grid predictor held in a small scoreboard class
// depends on jhs_pkg and the core rtl
`timescale 1ns / 1ps

class heat_scoreboard;
   localparam int SIDE_MAX = jhs_pkg::MAX_SIDE_DEF;

   typedef struct packed {
      logic [jhs_pkg::TEMP_W-1:0] cell_value;
      logic                       run_done;
   } cell_report_type;

   logic [jhs_pkg::TEMP_W-1:0]  plane [2][SIDE_MAX*SIDE_MAX];
   bit                          live_half;
   logic [jhs_pkg::SWEEP_W-1:0] sweep_cfg;
   logic [jhs_pkg::GRID_W-1:0]  side_cfg;
   cell_report_type             awaited_q[$];
   int                          fail_count;

   function new();
      live_half  = 1'b0;
      sweep_cfg  = jhs_pkg::SWEEP_COUNT_RST;
      side_cfg   = jhs_pkg::GRID_SIZE_RST;
      fail_count = 0;
   endfunction

   function void set_register(logic [jhs_pkg::CSR_IDX_W-1:0] idx,
                              logic [jhs_pkg::CSR_DATA_W-1:0] data);
      if (idx == jhs_pkg::CSR_SWEEP_COUNT) begin
         sweep_cfg = data[jhs_pkg::SWEEP_W-1:0];
      end else begin
         side_cfg = data[jhs_pkg::GRID_W-1:0];
      end
   endfunction

   // one jacobi pass from the live half into the other one, then flip
   function void relax_once();
      int                        side;
      int                        src;
      int                        dst;
      logic [jhs_pkg::SUM_W-1:0] total;
      side = (int'(side_cfg) < SIDE_MAX) ? int'(side_cfg) : SIDE_MAX;
      src  = int'(live_half);
      dst  = int'(!live_half);
      for (int r = 1; r + 1 < side; r++) begin
         for (int c = 1; c + 1 < side; c++) begin
            total = {2'b00, plane[src][(r-1)*SIDE_MAX+c]}
                  + {2'b00, plane[src][(r+1)*SIDE_MAX+c]}
                  + {2'b00, plane[src][r*SIDE_MAX+c-1]}
                  + {2'b00, plane[src][r*SIDE_MAX+c+1]};
            plane[dst][r*SIDE_MAX+c] = total[jhs_pkg::SUM_W-1:2];
         end
      end
      live_half = !live_half;
   endfunction

   function void note_input(logic [jhs_pkg::CMD_W-1:0] cmd, logic [6:0] row,
                            logic [6:0] col, logic [jhs_pkg::TEMP_W-1:0] temp);
      int              idx;
      cell_report_type exp_cell;
      // 7-bit coordinates never reach the 128 limit, so every cell is inside
      idx = row * SIDE_MAX + col;
      case (cmd)
         jhs_pkg::CMD_WRITE: begin
            plane[0][idx] = temp;
            plane[1][idx] = temp;
         end
         jhs_pkg::CMD_RUN: begin
            for (int n = 0; n < sweep_cfg; n++) relax_once();
            exp_cell.cell_value = '0;
            exp_cell.run_done   = 1'b1;
            awaited_q.push_back(exp_cell);
         end
         jhs_pkg::CMD_READ: begin
            exp_cell.cell_value = plane[live_half][idx];
            exp_cell.run_done   = 1'b0;
            awaited_q.push_back(exp_cell);
         end
         default: ;
      endcase
   endfunction

   task report(string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task check_result(logic [jhs_pkg::TEMP_W-1:0] value, logic done);
      cell_report_type exp_cell;
      if (awaited_q.size() == 0) begin
         report($sformatf("unexpected result value=%h done=%b", value, done));
      end else begin
         exp_cell = awaited_q.pop_front();
         if (value !== exp_cell.cell_value)
            report($sformatf("cell_value %h, expected %h", value, exp_cell.cell_value));
         if (done !== exp_cell.run_done)
            report($sformatf("run_done %b, expected %b", done, exp_cell.run_done));
      end
   endtask
endclass

module testbench;
   localparam int SIDE_MAX      = jhs_pkg::MAX_SIDE_DEF;
   localparam int RANDOM_ITEMS  = 600;
   localparam int CALM_TAIL     = 60;
   // longest quiet stretch is a 65535-sweep run on a 3x3 grid
   localparam int STALL_LIMIT   = 1_600_000;
   localparam logic [jhs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic [jhs_pkg::CMD_W-1:0]         req_command = '0;
   logic [jhs_pkg::COORD_W-1:0]       req_row = '0;
   logic [jhs_pkg::COORD_W-1:0]       req_column = '0;
   logic [jhs_pkg::TEMP_W-1:0]        req_temperature = '0;
   logic                              csr_we = 1'b0;
   logic [jhs_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [jhs_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;
   wire logic                         busy;
   wire logic                         rsp_valid;
   wire logic [jhs_pkg::TEMP_W-1:0]   rsp_cell_value;
   wire logic                         rsp_run_done;

   heat_scoreboard sb;
   // cells loaded so far; reads and sweeps only ever touch these
   bit   written_map [SIDE_MAX*SIDE_MAX];
   int   written_list[$];
   int   served = 0;
   int   random_goal = 0;
   int   quiet_cycles = 0;
   int   side_now = int'(jhs_pkg::GRID_SIZE_RST);

   jacobi_heat_stencil_core uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_row         (req_row),
      .req_column      (req_column),
      .req_temperature (req_temperature),
      .rsp_valid       (rsp_valid),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_run_done    (rsp_run_done),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // result side: every strobe is a transfer, no backpressure possible
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_result(rsp_cell_value, rsp_run_done);
   end

   // watchdog: cycles with neither a command nor a result transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one command transfer; start stays high afterwards for back-to-back issue
   task issue(input logic [jhs_pkg::CMD_W-1:0] cmd, input logic [6:0] row,
              input logic [6:0] col, input logic [jhs_pkg::TEMP_W-1:0] temp);
      @(negedge clock);
      start           <= 1'b1;
      req_command     <= cmd;
      req_row         <= row;
      req_column      <= col;
      req_temperature <= temp;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_input(cmd, row, col, temp);
      if (cmd == jhs_pkg::CMD_WRITE && !written_map[row*SIDE_MAX+col]) begin
         written_map[row*SIDE_MAX+col] = 1'b1;
         written_list.push_back(row*SIDE_MAX+col);
      end
      if (cmd != CMD_UNUSED) served++;
   endtask

   task idle(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop sending and let every outstanding result come home
   task drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.awaited_q.size() != 0) @(posedge clock);
      // a trailing write gives no result, so allow its cycle to finish
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // register write, only called with the core idle
   task write_reg(input logic [jhs_pkg::CSR_IDX_W-1:0] idx,
                  input logic [jhs_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      if (idx == jhs_pkg::CSR_GRID_SIZE)
         side_now = (int'(data[7:0]) < SIDE_MAX) ? int'(data[7:0]) : SIDE_MAX;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [jhs_pkg::TEMP_W-1:0] pick_temp();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return jhs_pkg::TEMP_W'($urandom);
      endcase
   endfunction

   // sender gaps in bursts, none in the closing stretch or in quiet phases
   task pace(input bit steady);
      if (!steady && served < random_goal - CALM_TAIL) begin
         if ($urandom_range(0, 39) == 0) drain();
         else if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 11));
      end
   endtask

   task random_phase();
      logic [jhs_pkg::GRID_W-1:0]  grid;
      logic [jhs_pkg::SWEEP_W-1:0] sweeps;
      logic [6:0]                  row;
      logic [6:0]                  col;
      int                          pick;
      int                          count;
      bit                          steady;
      drain();
      // big grids only with zero sweeps, otherwise a run would take too long
      if ($urandom_range(0, 9) == 0) begin
         grid   = 8'($urandom_range(17, 128));
         sweeps = '0;
      end else begin
         grid   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 16))
                                               : 8'($urandom_range(3, 8));
         sweeps = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(4, 10))
                                               : 16'($urandom_range(0, 3));
      end
      write_reg(jhs_pkg::CSR_GRID_SIZE, {8'd0, grid});
      write_reg(jhs_pkg::CSR_SWEEP_COUNT, sweeps);
      steady = ($urandom_range(0, 3) == 0);
      // every cell in the active square must hold data before a sweep reads it
      if (sweeps != 0) begin
         for (int r = 0; r < side_now; r++) begin
            for (int c = 0; c < side_now; c++) begin
               if (!written_map[r*SIDE_MAX+c]) begin
                  pace(steady);
                  issue(jhs_pkg::CMD_WRITE, 7'(r), 7'(c), pick_temp());
               end
            end
         end
      end
      count = $urandom_range(20, 50);
      for (int i = 0; i < count; i++) begin
         pace(steady);
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            if ($urandom_range(0, 9) < 7) begin
               row = 7'($urandom_range(0, side_now - 1));
               col = 7'($urandom_range(0, side_now - 1));
            end else begin
               row = 7'($urandom_range(0, 127));
               col = 7'($urandom_range(0, 127));
            end
            issue(jhs_pkg::CMD_WRITE, row, col, pick_temp());
         end else if (pick < 80) begin
            if ($urandom_range(0, 1) == 0) begin
               row = 7'($urandom_range(0, side_now - 1));
               col = 7'($urandom_range(0, side_now - 1));
            end else begin
               row = 7'($urandom_range(0, 127));
               col = 7'($urandom_range(0, 127));
            end
            // never read a cell that has no data yet
            if (!written_map[row*SIDE_MAX+col]) begin
               pick = written_list[$urandom_range(0, written_list.size() - 1)];
               row  = 7'(pick / SIDE_MAX);
               col  = 7'(pick % SIDE_MAX);
            end
            issue(jhs_pkg::CMD_READ, row, col, pick_temp());
         end else if (pick < 95) begin
            issue(jhs_pkg::CMD_RUN, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  pick_temp());
         end else begin
            issue(CMD_UNUSED, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  pick_temp());
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corners of the full store, the ignored code, read-back at default size
      issue(jhs_pkg::CMD_WRITE, 7'd0, 7'd0, 16'h0000);
      issue(jhs_pkg::CMD_WRITE, 7'd127, 7'd127, 16'hFFFF);
      issue(jhs_pkg::CMD_WRITE, 7'd127, 7'd0, 16'h5A5A);
      issue(jhs_pkg::CMD_WRITE, 7'd0, 7'd127, 16'h8001);
      issue(CMD_UNUSED, 7'd127, 7'd127, 16'hFFFF);
      issue(jhs_pkg::CMD_READ, 7'd127, 7'd127, 16'h0000);
      issue(jhs_pkg::CMD_READ, 7'd0, 7'd0, 16'hFFFF);
      issue(jhs_pkg::CMD_READ, 7'd127, 7'd0, 16'h0000);
      issue(jhs_pkg::CMD_READ, 7'd0, 7'd127, 16'h0000);

      // smallest grid; full-scale neighbors stress the sum width
      drain();
      write_reg(jhs_pkg::CSR_GRID_SIZE, 16'd3);
      write_reg(jhs_pkg::CSR_SWEEP_COUNT, 16'd0);
      issue(jhs_pkg::CMD_WRITE, 7'd0, 7'd1, 16'hFFFF);
      issue(jhs_pkg::CMD_WRITE, 7'd1, 7'd0, 16'hFFFF);
      issue(jhs_pkg::CMD_WRITE, 7'd1, 7'd2, 16'hFFFF);
      issue(jhs_pkg::CMD_WRITE, 7'd2, 7'd1, 16'hFFFF);
      issue(jhs_pkg::CMD_WRITE, 7'd1, 7'd1, 16'h1234);
      issue(jhs_pkg::CMD_WRITE, 7'd0, 7'd2, 16'h0000);
      issue(jhs_pkg::CMD_WRITE, 7'd2, 7'd0, 16'h0000);
      issue(jhs_pkg::CMD_WRITE, 7'd2, 7'd2, 16'h0000);
      // zero sweeps still reports done and leaves the grid alone
      issue(jhs_pkg::CMD_RUN, 7'd0, 7'd0, 16'h0000);
      issue(jhs_pkg::CMD_READ, 7'd1, 7'd1, 16'h0000);

      drain();
      write_reg(jhs_pkg::CSR_SWEEP_COUNT, 16'd1);
      issue(jhs_pkg::CMD_RUN, 7'd0, 7'd0, 16'h0000);
      issue(jhs_pkg::CMD_READ, 7'd1, 7'd1, 16'h0000);
      // neighbor sum that is not a multiple of four checks the truncating shift
      issue(jhs_pkg::CMD_WRITE, 7'd1, 7'd2, 16'h0001);
      issue(jhs_pkg::CMD_RUN, 7'd0, 7'd0, 16'h0000);
      issue(jhs_pkg::CMD_READ, 7'd1, 7'd1, 16'h0000);

      // longest run the register allows, on the cheapest grid
      drain();
      write_reg(jhs_pkg::CSR_SWEEP_COUNT, 16'hFFFF);
      issue(jhs_pkg::CMD_RUN, 7'd0, 7'd0, 16'h0000);
      issue(jhs_pkg::CMD_READ, 7'd1, 7'd1, 16'h0000);
      issue(jhs_pkg::CMD_READ, 7'd0, 7'd1, 16'h0000);

      // largest grid with an empty run
      drain();
      write_reg(jhs_pkg::CSR_GRID_SIZE, 16'd128);
      write_reg(jhs_pkg::CSR_SWEEP_COUNT, 16'd0);
      issue(jhs_pkg::CMD_RUN, 7'd0, 7'd0, 16'h0000);
      issue(jhs_pkg::CMD_READ, 7'd127, 7'd127, 16'h0000);

      random_goal = served + RANDOM_ITEMS;
      while (served < random_goal) random_phase();

      drain();
      repeat (10) @(posedge clock);
      if (sb.awaited_q.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.awaited_q.size()));
      if (sb.fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// File: jacobi_heat_stencil_core.f
+incdir+design
design/jhs_pkg.sv
design/jhs_ram.sv
design/jhs_sweep_seq.sv
design/jacobi_heat_stencil_core.sv
design/jhs_checker.sv
tb/testbench.sv
